/* hdl/fnpll_pkg.sv */
package fnpll_pkg;

  localparam int REF_W    = 28;
  localparam int CNT_W    = 10;
  localparam int TGT_W    = 33;
  localparam int PFD_W    = 29;
  localparam int EXP_W    = 3;
  localparam int INT_W    = 16;
  localparam int FRAC_W   = 12;
  localparam int STAT_W   = 2;
  localparam int STEP_W   = 6;

  localparam int MAX_DIV_EXP_DEF = 6;

  localparam logic [TGT_W-1:0] VCO_MIN   = 33'd2200000000;
  localparam logic [PFD_W-1:0] PFD_LIMIT = 29'd32000000;
  localparam logic [INT_W-1:0] INT_MAX   = 16'hffff;

  localparam logic [REF_W-1:0] REF_FREQ_RST    = 28'd25000000;
  localparam logic [CNT_W-1:0] REF_COUNTER_RST = 10'd256;

  // register indexes on the configuration port
  localparam logic [1:0] REG_REF_FREQ    = 2'd0;
  localparam logic [1:0] REG_REF_DOUBLER = 2'd1;
  localparam logic [1:0] REG_REF_HALVER  = 2'd2;
  localparam logic [1:0] REG_REF_COUNTER = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BELOW     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_PFD  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_INT_OVF   = 2'd3;

  // quotient bits produced by each division pass
  localparam logic [STEP_W-1:0] PFD_STEPS  = 6'd29;
  localparam logic [STEP_W-1:0] QUO_STEPS  = 6'd33;
  localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd12;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

/* hdl/fnpll_div.sv */
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// MSB-aligned; quotient bits enter at the bottom of the same register.
module fnpll_div
  import fnpll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [TGT_W-1:0] dividend,
  input  logic [PFD_W-1:0] divisor,
  input  logic [PFD_W-1:0] rem_init,
  output logic             busy,
  output logic [TGT_W-1:0] quot,
  output logic [PFD_W-1:0] rem
);

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [TGT_W-1:0]  q_r, q_nxt;
  logic [PFD_W-1:0]  p_r, p_nxt;
  logic [PFD_W-1:0]  d_r, d_nxt;

  logic [PFD_W:0] trial;
  logic [PFD_W:0] diff;
  logic           ge;

  assign trial = {p_r, q_r[TGT_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    p_nxt   = p_r;
    d_nxt   = d_r;
    if (ctl.start) begin
      cnt_nxt = ctl.steps;
      q_nxt   = dividend;
      p_nxt   = rem_init;
      d_nxt   = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      q_nxt   = {q_r[TGT_W-2:0], ge};
      p_nxt   = ge ? diff[PFD_W-1:0] : trial[PFD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    p_r <= p_nxt;
    d_r <= d_nxt;
  end

  assign busy = cnt_r != '0;
  assign quot = q_r;
  assign rem  = p_r;

endmodule

/* hdl/frac_n_pll_divider_calc_top.sv */
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, in_target_freq
// out     | output    | out_valid, out_ready, out_div_exponent ... out_status
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One word runs the PFD division, then the integer divider and then the fraction,
// all through one bit-serial divider; a zero PFD or an integer overflow ends it
// early. The exponent search runs during the PFD pass.
// Reset loads the reference defaults and empties the output register.
// A finished word waits in the output register; the next word is taken meanwhile.
module frac_n_pll_divider_calc_top
  import fnpll_pkg::*;
#(
  parameter int MAX_DIV_EXP = MAX_DIV_EXP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TGT_W-1:0]  in_target_freq,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EXP_W-1:0]  out_div_exponent,
  output logic [TGT_W-1:0]  out_vco_hz,
  output logic [INT_W-1:0]  out_int_part,
  output logic [FRAC_W-1:0] out_frac_part,
  output logic [PFD_W-1:0]  out_pfd_hz,
  output logic              out_pfd_over_limit,
  output logic [STAT_W-1:0] out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [REF_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PFD  = 5'b00010,
    S_QUO  = 5'b00100,
    S_FRAC = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [REF_W-1:0] ref_freq_r;
  logic             ref_doubler_r;
  logic             ref_halver_r;
  logic [CNT_W-1:0] ref_counter_r;

  logic [TGT_W-1:0]  vco_r, vco_nxt;
  logic [EXP_W-1:0]  k_r, k_nxt;
  logic [PFD_W-1:0]  pfd_r, pfd_nxt;
  logic [INT_W-1:0]  int_r, int_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r;
  logic [EXP_W-1:0]  o_exp_r;
  logic [TGT_W-1:0]  o_vco_r;
  logic [INT_W-1:0]  o_int_r;
  logic [FRAC_W-1:0] o_frac_r;
  logic [PFD_W-1:0]  o_pfd_r;
  logic              o_over_r;
  logic [STAT_W-1:0] o_stat_r;

  div_ctl_t         div_ctl;
  logic [TGT_W-1:0] div_dividend;
  logic [PFD_W-1:0] div_divisor;
  logic [PFD_W-1:0] div_rem_init;
  logic             div_busy;
  logic [TGT_W-1:0] div_quot;
  logic [PFD_W-1:0] div_rem;

  logic [PFD_W-1:0]          ref_dbl;
  logic [PFD_W-1:0]          ref_eff;
  logic                      r_zero;
  logic                      vco_low;
  logic                      vco_shift;
  logic [PFD_W-1:0]          pfd_new;
  logic [PFD_W+FRAC_W-1:0]   frac_num;
  logic                      out_free;
  logic [STAT_W-1:0]         status;

  fnpll_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rem_init (div_rem_init),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign ref_dbl   = ref_doubler_r ? {ref_freq_r, 1'b0} : {1'b0, ref_freq_r};
  assign ref_eff   = ref_halver_r ? (ref_dbl >> 1) : ref_dbl;
  assign r_zero    = ref_counter_r == '0;
  assign vco_low   = vco_r < VCO_MIN;
  assign vco_shift = vco_low && (k_r < EXP_W'(MAX_DIV_EXP));
  assign pfd_new   = r_zero ? '0 : div_quot[PFD_W-1:0];
  // remainder times 4095 as a shift and subtract
  assign frac_num  = {div_rem, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, div_rem};
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (pfd_r == '0) begin
      status = STAT_ZERO_PFD;
    end else if (vco_low) begin
      status = STAT_BELOW;
    end else if (ovf_r) begin
      status = STAT_INT_OVF;
    end else begin
      status = STAT_OK;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    vco_nxt      = vco_r;
    k_nxt        = k_r;
    pfd_nxt      = pfd_r;
    int_nxt      = int_r;
    frac_nxt     = frac_r;
    ovf_nxt      = ovf_r;
    div_ctl      = '{start: 1'b0, steps: PFD_STEPS};
    div_dividend = {ref_eff, {(TGT_W-PFD_W){1'b0}}};
    div_divisor  = {{(PFD_W-CNT_W){1'b0}}, ref_counter_r};
    div_rem_init = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          vco_nxt       = in_target_freq;
          k_nxt         = '0;
          int_nxt       = '0;
          frac_nxt      = '0;
          ovf_nxt       = 1'b0;
          div_ctl.start = !r_zero;
          state_nxt     = S_PFD;
        end
      end
      S_PFD: begin
        if (vco_shift) begin
          vco_nxt = {vco_r[TGT_W-2:0], 1'b0};
          k_nxt   = k_r + 1'b1;
        end else if (!div_busy) begin
          pfd_nxt = pfd_new;
          if (pfd_new != '0) begin
            div_ctl      = '{start: 1'b1, steps: QUO_STEPS};
            div_dividend = vco_r;
            div_divisor  = pfd_new;
            state_nxt    = S_QUO;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_QUO: begin
        if (!div_busy) begin
          if (div_quot[TGT_W-1:INT_W] != '0) begin
            int_nxt   = INT_MAX;
            ovf_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            int_nxt      = div_quot[INT_W-1:0];
            div_ctl      = '{start: 1'b1, steps: FRAC_STEPS};
            div_dividend = {frac_num[FRAC_W-1:0], {(TGT_W-FRAC_W){1'b0}}};
            div_divisor  = pfd_r;
            div_rem_init = frac_num[PFD_W+FRAC_W-1:FRAC_W];
            state_nxt    = S_FRAC;
          end
        end
      end
      S_FRAC: begin
        if (!div_busy) begin
          frac_nxt  = div_quot[FRAC_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      ref_freq_r    <= REF_FREQ_RST;
      ref_doubler_r <= 1'b0;
      ref_halver_r  <= 1'b0;
      ref_counter_r <= REF_COUNTER_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_REF_FREQ:    ref_freq_r    <= cfg_data;
          REG_REF_DOUBLER: ref_doubler_r <= cfg_data[0];
          REG_REF_HALVER:  ref_halver_r  <= cfg_data[0];
          REG_REF_COUNTER: ref_counter_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
    vco_r  <= vco_nxt;
    k_r    <= k_nxt;
    pfd_r  <= pfd_nxt;
    int_r  <= int_nxt;
    frac_r <= frac_nxt;
    ovf_r  <= ovf_nxt;
    // hold the word until it is taken
    if (state_r == S_DONE && out_free) begin
      o_exp_r  <= k_r;
      o_vco_r  <= vco_r;
      o_int_r  <= int_r;
      o_frac_r <= frac_r;
      o_pfd_r  <= pfd_r;
      o_over_r <= pfd_r > PFD_LIMIT;
      o_stat_r <= status;
    end
  end

  assign in_ready           = state_r == S_IDLE;
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_div_exponent   = o_exp_r;
  assign out_vco_hz         = o_vco_r;
  assign out_int_part       = o_int_r;
  assign out_frac_part      = o_frac_r;
  assign out_pfd_hz         = o_pfd_r;
  assign out_pfd_over_limit = o_over_r;
  assign out_status         = o_stat_r;

endmodule
